FILE: rtl/iqtr_pkg.sv
// Shared types, codes and constants of the quarter-turn image rotator.
`timescale 1ns / 1ps

package iqtr_pkg;

  // Default frame store geometry.
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // Fixed field widths.
  localparam int PIX_W = 32;
  localparam int CFG_W = 9;

  // Alpha is the top byte; this mask keeps red, green and blue.
  localparam logic [PIX_W-1:0] RGB_MASK = 32'h00FF_FFFF;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_ALPHA_PRESENT = 2'd2,
    REG_TURN_CODE     = 2'd3
  } cfg_reg_t;

  // Input item kinds.
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_t;

  // Turn selections (counter-clockwise angles).
  typedef enum logic [1:0] {
    TURN_0   = 2'd0,
    TURN_90  = 2'd1,
    TURN_180 = 2'd2,
    TURN_270 = 2'd3
  } turn_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_LOAD_FULL   = 2'd1,
    STAT_FETCH_EARLY = 2'd2
  } status_t;

endpackage

FILE: rtl/iqtr_frame_store.sv
// Frame store: single write port, single read port, registered read data.
`timescale 1ns / 1ps

module iqtr_frame_store import iqtr_pkg::*; #(
  parameter int DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [PIX_W-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [PIX_W-1:0]         rd_data
);

  logic [PIX_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/iqtr_addr_gen.sv
// Fetch walk: destination position, turn mapping and store address.
`timescale 1ns / 1ps

module iqtr_addr_gen import iqtr_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]             width,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]            height,
  input  turn_t                                      turn,
  input  logic                                       advance,
  output logic                                       last,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]    addr
);

  localparam int WD_W    = $clog2(MAX_WIDTH + 1);
  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int PROD_W  = POS_W + WD_W;

  logic [POS_W-1:0]  out_row;
  logic [POS_W-1:0]  out_col;
  logic [POS_W-1:0]  src_row;
  logic [POS_W-1:0]  src_col;
  logic [DIM_W-1:0]  w_ext;
  logic [DIM_W-1:0]  h_ext;
  logic [DIM_W-1:0]  dst_w;
  logic [DIM_W-1:0]  dst_h;
  logic [DIM_W-1:0]  r;
  logic [DIM_W-1:0]  c;
  logic [DIM_W-1:0]  sr;
  logic [DIM_W-1:0]  sc;
  logic              col_end;
  logic              row_end;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] addr_sum;

  // Destination size: a quarter turn swaps width and height.
  assign w_ext = DIM_W'(width);
  assign h_ext = DIM_W'(height);
  assign dst_w = turn[0] ? h_ext : w_ext;
  assign dst_h = turn[0] ? w_ext : h_ext;

  // Position saturated to the current destination size.
  assign r = (DIM_W'(out_row) < dst_h) ? DIM_W'(out_row) : dst_h - DIM_W'(1);
  assign c = (DIM_W'(out_col) < dst_w) ? DIM_W'(out_col) : dst_w - DIM_W'(1);

  assign col_end = (c == dst_w - DIM_W'(1));
  assign row_end = (r == dst_h - DIM_W'(1));
  assign last    = col_end && row_end;

  // Map destination position to source row and column.
  always_comb begin
    unique case (turn)
      TURN_90: begin
        sr = c;
        sc = w_ext - DIM_W'(1) - r;
      end
      TURN_180: begin
        sr = h_ext - DIM_W'(1) - r;
        sc = w_ext - DIM_W'(1) - c;
      end
      TURN_270: begin
        sr = h_ext - DIM_W'(1) - c;
        sc = r;
      end
      default: begin
        sr = r;
        sc = c;
      end
    endcase
  end

  // Raster walk over the destination image.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_row <= '0;
      out_col <= '0;
    end else if (advance) begin
      if (last) begin
        out_row <= '0;
        out_col <= '0;
      end else if (col_end) begin
        out_row <= POS_W'(r + DIM_W'(1));
        out_col <= '0;
      end else begin
        out_row <= POS_W'(r);
        out_col <= POS_W'(c + DIM_W'(1));
      end
    end
  end

  // Source position is captured when the walk advances.
  always_ff @(posedge clk) begin
    if (advance) begin
      src_row <= POS_W'(sr);
      src_col <= POS_W'(sc);
    end
  end

  // Row-major store address, registered for the memory read.
  assign prod     = PROD_W'(src_row) * PROD_W'(width);
  assign addr_sum = prod + PROD_W'(src_col);

  always_ff @(posedge clk) begin
    addr <= ADDR_W'(addr_sum);
  end

endmodule

FILE: rtl/image_quarter_turn_rotator_unit.sv
// Top level of the quarter-turn image rotator.
//
//  Channel  Direction  Handshake         Payload
//  s_*      in         tvalid / tready   tdata: pixel_in; tuser: command
//  m_*      out        tvalid / tready   tdata: pixel_out; tlast: last_pixel; tuser: status
//  cfg_*    in         valid / ready     cfg_index: register; cfg_data: value
//
// One item is in flight at a time. A load passes from the execute state to the result
// state; a fetch (position, address multiply, registered memory read, result) passes
// through the execute, address, read and result states until its result is loaded.
// The output register holds a result while the master side stalls; the next
// item is accepted meanwhile and waits in the result state until it drains.
// Reset restores the default configuration and clears counters and fetch position, not the frame store.
`timescale 1ns / 1ps

module image_quarter_turn_rotator_unit import iqtr_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // Input stream.
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [PIX_W-1:0] s_tdata,    // [31:0] pixel_in
  input  logic             s_tuser,    // [0] command
  // Output stream.
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [PIX_W-1:0] m_tdata,    // [31:0] pixel_out
  output logic             m_tlast,
  output logic [1:0]       m_tuser,    // [1:0] status
  // Configuration writes.
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int HD_W   = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_ADDR   = 5'b00100,
    S_READ   = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  image_height;
  logic              alpha_present;
  turn_t             turn_code;
  logic [WD_W-1:0]   w;
  logic [HD_W-1:0]   h;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  load_count;
  logic [CNT_W-1:0]  load_count_next;
  logic              frame_complete;
  cmd_t              cmd;
  logic [PIX_W-1:0]  pix;
  status_t           res_status;
  logic              res_last;
  logic              res_mem;
  logic              store_we;
  logic              fetch_adv;
  logic              fetch_last;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  rd_data;
  logic              out_load;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= CFG_W'(1);
      image_height  <= CFG_W'(1);
      alpha_present <= 1'b1;
      turn_code     <= TURN_0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        REG_ALPHA_PRESENT: alpha_present <= cfg_data[0];
        REG_TURN_CODE:     turn_code     <= turn_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // Sizes clamped to the store geometry; zero acts as one.
  always_comb begin
    if (image_width == '0) begin
      w = WD_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w = WD_W'(MAX_WIDTH);
    end else begin
      w = WD_W'(image_width);
    end
    if (image_height == '0) begin
      h = HD_W'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h = HD_W'(MAX_HEIGHT);
    end else begin
      h = HD_W'(image_height);
    end
  end

  // Pixel count of the frame, registered off the multiplier.
  always_ff @(posedge clk) begin
    total <= CNT_W'(w) * CNT_W'(h);
  end

  assign load_count_next = load_count + CNT_W'(1);
  assign store_we  = (state == S_EXEC) && (cmd == CMD_LOAD) && !frame_complete
                     && (load_count < total);
  assign fetch_adv = (state == S_EXEC) && (cmd == CMD_FETCH) && frame_complete;
  assign s_tready  = (state == S_IDLE);
  assign out_load  = (state == S_RESULT) && (!m_tvalid || m_tready);

  // Transaction sequencer and frame bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      load_count     <= '0;
      frame_complete <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd == CMD_LOAD) begin
            state <= S_RESULT;
            if (store_we) begin
              load_count <= load_count_next;
              if (load_count_next >= total) begin
                frame_complete <= 1'b1;
              end
            end else begin
              frame_complete <= 1'b1;
            end
          end else if (!frame_complete) begin
            state <= S_RESULT;
          end else begin
            state <= S_ADDR;
            if (fetch_last) begin
              load_count     <= '0;
              frame_complete <= 1'b0;
            end
          end
        end
        S_ADDR: begin
          state <= S_READ;
        end
        S_READ: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Input capture and pending result fields.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd <= cmd_t'(s_tuser);
      pix <= s_tdata;
    end
    if (state == S_EXEC) begin
      res_mem  <= fetch_adv;
      res_last <= fetch_adv && fetch_last;
      if (cmd == CMD_LOAD) begin
        res_status <= store_we ? STAT_OK : STAT_LOAD_FULL;
      end else begin
        res_status <= frame_complete ? STAT_OK : STAT_FETCH_EARLY;
      end
    end
  end

  iqtr_addr_gen #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_addr_gen (
    .clk     (clk),
    .rst     (rst),
    .width   (w),
    .height  (h),
    .turn    (turn_code),
    .advance (fetch_adv),
    .last    (fetch_last),
    .addr    (rd_addr)
  );

  iqtr_frame_store #(
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk     (clk),
    .wr_en   (store_we),
    .wr_addr (load_count[ADDR_W-1:0]),
    .wr_data (pix),
    .rd_en   (state == S_READ),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (res_mem) begin
        m_tdata <= alpha_present ? rd_data : (rd_data & RGB_MASK);
      end else begin
        m_tdata <= '0;
      end
      m_tlast <= res_last;
      m_tuser <= res_status;
    end
  end

  // The store is never written past the current frame size.
  assert property (@(posedge clk) disable iff (rst)
    store_we |-> (load_count < total))
    else $error("frame store write beyond frame size");

  // The final fetch releases the frame for the next image.
  assert property (@(posedge clk) disable iff (rst)
    (fetch_adv && fetch_last) |=> (load_count == '0) && !frame_complete)
    else $error("frame not released after final pixel");

  // Only a successful fetch can mark the final pixel.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tuser == STAT_OK))
    else $error("final pixel flagged on a refused transaction");

  // An accepted transaction always enters execution next.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_EXEC))
    else $error("accepted transaction not executed");

endmodule
